>>> sv/f48_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f48_pkg: shared types and constants for the 48-bit float unit
// Operation codes, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package f48_pkg;

    localparam int unsigned ExpBias = 16384;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ADD,
        ST_NORM,
        ST_MUL,
        ST_DIV,
        ST_DIVFIN,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic add_step;
        logic norm_step;
        logic mul_step;
        logic div_step;
        logic div_fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic norm_done;
        logic div_last;
    } t_status;

endpackage

>>> sv/f48_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f48_ctrl: sequencer for the 48-bit float unit
// Steps one request through load, the operation and the output register.
// ----------------------------------------------------------------------------
module f48_ctrl
    import f48_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_op     i_op,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_op)
                        OP_MUL:  n_state = ST_MUL;
                        OP_DIV:  n_state = ST_DIV;
                        default: n_state = ST_ADD;
                    endcase
                end
            end
            ST_ADD: begin
                o_cmd.add_step = 1'b1;
                n_state = ST_NORM;
            end
            ST_NORM: begin
                o_cmd.norm_step = 1'b1;
                if (i_status.norm_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_OUT;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_DIVFIN;
                end
            end
            ST_DIVFIN: begin
                o_cmd.div_fin = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.load, o_cmd.add_step, o_cmd.norm_step, o_cmd.mul_step,
                    o_cmd.div_step, o_cmd.div_fin}) <= 1)
        else $error("more than one datapath command");
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_fin |=> o_out_valid)
        else $error("divide finish not followed by result");
    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready while result pending");

endmodule

>>> sv/f48_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f48_dp: datapath for the 48-bit float unit
// Operand registers, aligner, adder, one-bit normalizer, multiplier and a
// radix-2 restoring divider.
// ----------------------------------------------------------------------------
module f48_dp
    import f48_pkg::*;
(
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_a0,
    input  logic [15:0] i_a1,
    input  logic [15:0] i_a2,
    input  logic [15:0] i_b0,
    input  logic [15:0] i_b1,
    input  logic [15:0] i_b2,
    output t_status     o_status,
    output logic [15:0] o_w0,
    output logic [15:0] o_w1,
    output logic [15:0] o_w2,
    output logic        o_dbz
);

    logic        r_sa, r_sb, r_zero, r_sign;
    logic [14:0] r_ea, r_eb;
    logic [31:0] r_ma, r_mb, r_m;
    logic [17:0] r_e;                      // signed unbiased exponent
    logic [63:0] r_prod;
    logic [32:0] r_rem;
    logic [33:0] r_q;
    logic        r_hi;                     // a quotient bit fell off the top
    logic [5:0]  r_cnt;
    logic        r_nz;                     // dividend nonzero
    logic        r_nonorm;                 // result is final without shifting

    // Add / subtract alignment.
    logic        a_big, opp;
    logic [14:0] ediff;
    logic [31:0] mp, mq, mqs, lost, sp, sq;
    logic [32:0] sum;
    logic        stk, sgp, sgq;
    logic [17:0] ep;

    always_comb begin
        a_big = (r_ea >= r_eb);
        opp   = r_sa ^ r_sb;
        ediff = a_big ? (r_ea - r_eb) : (r_eb - r_ea);
        mp    = a_big ? r_ma : r_mb;
        mq    = a_big ? r_mb : r_ma;
        sgp   = a_big ? r_sa : r_sb;
        sgq   = a_big ? r_sb : r_sa;
        ep    = {3'b000, (a_big ? r_ea : r_eb)} - 18'(ExpBias);
        mqs   = (ediff > 15'd31) ? 32'd0 : (mq >> ediff[4:0]);
        lost  = (ediff > 15'd31) ? 32'd0 : (mq & ((32'd1 << ediff[4:0]) - 32'd1));
        stk   = |lost;
        sp    = mp;
        sq    = mqs;
        if (opp && (mqs > mp)) begin
            sp = mqs;
            sq = mp;
        end
        sum = opp ? ({1'b0, sp} - {1'b0, sq}) : ({1'b0, sp} + {1'b0, sq});
    end

    logic [33:0] dtry;
    logic [31:0] wexp;
    assign dtry = {r_rem, r_ma[31]} - {2'b00, r_mb};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sa   <= i_a0[15];
            r_sb   <= i_b0[15] ^ (i_op == OP_SUB);
            r_ea   <= i_a0[14:0];
            r_eb   <= i_b0[14:0];
            r_ma   <= {i_a1, i_a2};
            r_mb   <= {i_b1, i_b2};
            r_zero <= 1'b0;
            r_rem  <= '0;
            r_q    <= '0;
            r_hi   <= 1'b0;
            r_nz   <= |{i_a1, i_a2};
            r_cnt  <= '0;
        end
        if (i_cmd.add_step) begin
            r_e <= ep;
            if (ediff > 15'd31) begin
                r_m      <= mp;
                r_sign   <= sgp;
                r_nonorm <= 1'b1;
            end else if (!opp) begin
                r_sign   <= sgp;
                r_nonorm <= 1'b1;
                if (sum[32]) begin
                    r_m <= sum[32:1];
                    r_e <= ep + 18'd1;
                end else begin
                    r_m <= sum[31:0] | {31'd0, stk};
                end
            end else begin
                r_sign   <= (mqs > mp) ? sgq : sgp;
                r_nonorm <= 1'b0;
                r_m      <= sum[31:0] | {31'd0, stk};
                r_zero   <= ~|(sum[31:0] | {31'd0, stk});
            end
        end
        if (i_cmd.norm_step && !o_status.norm_done) begin
            r_m <= {r_m[30:0], 1'b0};
            r_e <= r_e - 18'd1;
        end
        if (i_cmd.mul_step) begin
            r_prod <= r_ma * r_mb;
            r_e    <= ({3'b000, r_ea} - 18'(ExpBias)) + ({3'b000, r_eb} - 18'(ExpBias));
            r_sign <= r_sa ^ r_sb;
        end
        // The dividend mantissa shifts out of the top of r_ma, which then
        // supplies the appended zeros once its bits are used up.
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 6'd1;
            r_ma  <= {r_ma[30:0], 1'b0};
            r_hi  <= r_hi | r_q[33];
            if (!dtry[33]) begin
                r_rem <= dtry[32:0];
                r_q   <= {r_q[32:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_ma[31]};
                r_q   <= {r_q[32:0], 1'b0};
            end
        end
        if (i_cmd.div_fin) begin
            r_sign <= r_sa ^ r_sb;
        end
    end

    assign o_status.norm_done = r_zero || r_nonorm || r_m[31];
    assign o_status.div_last  = (r_cnt == 6'd63);

    // Multiply post-processing: one-bit normalize.
    logic [63:0] pm;
    logic [17:0] pe;
    always_comb begin
        pm = r_prod[63] ? r_prod : {r_prod[62:0], 1'b0};
        pe = r_prod[63] ? r_e : r_e - 18'd1;
    end

    // Divide post-processing. The low quotient bits live in r_q and r_hi
    // records any bit above them; a quotient above 32 bits shifts right once.
    logic [34:0] qr;
    logic [31:0] qm;
    logic [17:0] de;
    logic        ovf;
    always_comb begin
        qr  = {1'b0, r_q} + {34'd0, |r_rem};
        de  = ({3'b000, r_ea} - 18'(ExpBias)) - ({3'b000, r_eb} - 18'(ExpBias));
        ovf = r_hi || (|qr[34:32]);
        qm  = ovf ? qr[32:1] : qr[31:0];
        de  = ovf ? de + 18'd1 : de;
    end

    // Output register.
    logic [15:0] n_w0, n_w1, n_w2;
    logic        n_dbz;
    logic [15:0] r_w0, r_w1, r_w2;
    logic        r_od;
    assign wexp = 32'({{14{r_e[17]}}, r_e} + 32'(ExpBias));
    always_comb begin
        n_w0 = (wexp[15:0] | {r_sign, 15'd0});
        n_w1 = r_m[31:16];
        n_w2 = r_m[15:0];
        n_dbz = 1'b0;
        if (r_zero) begin
            n_w0 = '0; n_w1 = '0; n_w2 = '0;
        end
    end

    logic [31:0] mw, dw;
    assign mw = 32'({{14{pe[17]}}, pe} + 32'(ExpBias));
    assign dw = 32'({{14{de[17]}}, de} + 32'(ExpBias));

    // Marks the cycle after the product register is loaded.
    logic r_prod_pend;
    always_ff @(posedge i_clk) begin
        r_prod_pend <= i_cmd.mul_step;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_step && o_status.norm_done) begin
            r_w0 <= n_w0; r_w1 <= n_w1; r_w2 <= n_w2; r_od <= n_dbz;
        end
        if (i_cmd.mul_step) begin
            r_od <= 1'b0;
        end
        if (!i_cmd.mul_step && !i_cmd.load && r_prod_pend) begin
            if (pm == 64'd0 || $signed(pe) < $signed(-18'sd16383)) begin
                r_w0 <= '0; r_w1 <= '0; r_w2 <= '0;
            end else begin
                r_w0 <= mw[15:0] | {r_sign, 15'd0};
                r_w1 <= pm[63:48];
                r_w2 <= pm[47:32];
            end
        end
        if (i_cmd.div_fin) begin
            if (r_mb == 32'd0) begin
                r_w0 <= {r_sa, 15'h7FFF};
                r_w1 <= 16'hFFFF; r_w2 <= 16'hFFFF; r_od <= 1'b1;
            end else begin
                r_od <= 1'b0;
                if (!r_nz || $signed(de) < $signed(-18'sd16383)) begin
                    r_w0 <= '0; r_w1 <= '0; r_w2 <= '0;
                end else begin
                    r_w0 <= dw[15:0] | {r_sa ^ r_sb, 15'd0};
                    r_w1 <= qm[31:16]; r_w2 <= qm[15:0];
                end
            end
        end
    end

    assign o_w0  = r_w0;
    assign o_w1  = r_w1;
    assign o_w2  = r_w2;
    assign o_dbz = r_od;

    a_dbz_div: assert property (@(posedge i_clk)
        i_cmd.div_fin && (r_mb == 32'd0) |=> o_dbz)
        else $error("divide by zero flag missing");
    a_norm_top: assert property (@(posedge i_clk)
        i_cmd.norm_step && o_status.norm_done && !r_zero && !r_nonorm |-> r_m[31])
        else $error("normalizer left mantissa unnormalized");
    a_div_count: assert property (@(posedge i_clk)
        i_cmd.div_fin |-> (r_cnt == 6'd0))
        else $error("divide finished before all steps ran");

endmodule

>>> sv/float48_add_sub_mul_div_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float48_add_sub_mul_div_top: 48-bit float add, subtract, multiply, divide
// A sequencer drives a datapath holding operands, aligner, adder,
// normalizer, multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser = action, tdata = a_word0..b_word2
//  m_axis    out        tdata = res_word0..res_word2, tuser = divide_by_zero
//
// One request is taken at a time. Add and subtract pass through the left normalizer,
// which shifts one place per cycle. Multiply loads the product register and then
// the output register. Divide runs the 64 steps of the radix-2 divider.
// Reset returns the sequencer to idle; the result stays until taken.
module float48_add_sub_mul_div_top
    import f48_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // a_word0, a_word1, a_word2, b_word0..b_word2
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // res_word0, res_word1, res_word2
    output logic        m_axis_tuser    // divide_by_zero
);

    t_cmd    w_cmd;
    t_status w_status;

    f48_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (t_op'(s_axis_tuser)),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    f48_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_op     (s_axis_tuser),
        .i_a0     (s_axis_tdata[15:0]),
        .i_a1     (s_axis_tdata[31:16]),
        .i_a2     (s_axis_tdata[47:32]),
        .i_b0     (s_axis_tdata[63:48]),
        .i_b1     (s_axis_tdata[79:64]),
        .i_b2     (s_axis_tdata[95:80]),
        .o_status (w_status),
        .o_w0     (m_axis_tdata[15:0]),
        .o_w1     (m_axis_tdata[31:16]),
        .o_w2     (m_axis_tdata[47:32]),
        .o_dbz    (m_axis_tuser)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the 48-bit float add, subtract, multiply, divide unit
// Sends directed and random requests through the input stream, predicts each
// result from the operands, and compares every returned result word by word.
// ----------------------------------------------------------------------------
module tb_top;
    import f48_pkg::*;

    // Longest correct gap without a handshake is a divide plus the
    // longest receiver stall and sender gap; the limit leaves a wide margin.
    localparam int IdleLimit = 2000;
    localparam int DrainCycles = 80;

    typedef struct packed {
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic        dbz;
    } t_fres;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // a_word0, a_word1, a_word2, b_word0, b_word1, b_word2
    logic [1:0]  s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // res_word0, res_word1, res_word2
    logic        m_axis_tuser;   // divide_by_zero

    t_fres expected_results[$];
    int    fail_count;
    int    idle_cycles;
    int    burst_left;

    float48_add_sub_mul_div_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Builds the exponent word: biased exponent modulo 2^16 with the sign ORed in.
    function automatic logic [15:0] pack_exp(int e, logic s);
        logic [15:0] biased;
        biased = 16'(e + ExpBias);
        return biased | {s, 15'd0};
    endfunction

    function automatic logic [63:0] sticky_of(logic [63:0] m, int sc);
        if (sc == 0) return 64'd0;
        return ((m & ((64'd1 << sc) - 64'd1)) != 0) ? 64'd1 : 64'd0;
    endfunction

    // Predicts the result of one float request.
    function automatic t_fres float_result(t_op op, logic [15:0] aw0, logic [15:0] aw1,
                                           logic [15:0] aw2, logic [15:0] bw0,
                                           logic [15:0] bw1, logic [15:0] bw2);
        t_fres       r;
        logic        as, bs, ts, ps, qs;
        int          ae, be, pe, qe, te, sc, e;
        logic [63:0] am, bm, pm, qm, tm, m, g, num, q;
        r = '0;
        as = aw0[15];
        bs = bw0[15];
        ae = int'(aw0[14:0]) - ExpBias;
        be = int'(bw0[14:0]) - ExpBias;
        am = {32'd0, aw1, aw2};
        bm = {32'd0, bw1, bw2};
        if (op == OP_MUL) begin
            m = am * bm;
            e = ae + be;
            if (!m[63]) begin
                m = m << 1;
                e = e - 1;
            end
            if (m != 0 && e >= -16383) begin
                r.w0 = pack_exp(e, as ^ bs);
                r.w1 = m[63:48];
                r.w2 = m[47:32];
            end
            return r;
        end
        if (op == OP_DIV) begin
            if (bm == 0) begin
                r.w0 = aw0 | 16'h7FFF;
                r.w1 = 16'hFFFF;
                r.w2 = 16'hFFFF;
                r.dbz = 1'b1;
                return r;
            end
            num = am << 32;
            q = num / bm;
            if (num % bm != 0) q = q + 1;
            e = ae - be;
            if (q > 64'hFFFF_FFFF) begin
                q = q >> 1;
                e = e + 1;
            end
            if (num != 0 && e >= -16383) begin
                r.w0 = pack_exp(e, as ^ bs);
                r.w1 = q[31:16];
                r.w2 = q[15:0];
            end
            return r;
        end
        if (op == OP_SUB) bs = ~bs;
        // The operand with the larger exponent goes first; a keeps first place on a tie.
        ps = as; pe = ae; pm = am;
        qs = bs; qe = be; qm = bm;
        if (qe > pe) begin
            ts = ps; te = pe; tm = pm;
            ps = qs; pe = qe; pm = qm;
            qs = ts; qe = te; qm = tm;
        end
        sc = pe - qe;
        if (sc > 31) begin
            r.w0 = pack_exp(pe, ps);
            r.w1 = pm[31:16];
            r.w2 = pm[15:0];
            return r;
        end
        e = pe;
        if (as == bs) begin
            m = (pm + (qm >> sc)) | sticky_of(qm, sc);
            if (m > 64'hFFFF_FFFF) begin
                m = m >> 1;
                e = e + 1;
            end
        end else begin
            g = sticky_of(qm, sc);
            qm = qm >> sc;
            if (qm > pm) begin
                ps = qs;
                m = qm - pm;
            end else begin
                m = pm - qm;
            end
            m = m | g;
            if (m == 0) return r;
            while (!m[31]) begin
                m = m << 1;
                e = e - 1;
            end
        end
        r.w0 = pack_exp(e, ps);
        r.w1 = m[31:16];
        r.w2 = m[15:0];
        return r;
    endfunction

    // Sends one request in bursts with random gaps, and queues its prediction.
    // Valid stays high from one request to the next inside a burst.
    task automatic send_request(t_op op, logic [15:0] aw0, logic [15:0] aw1, logic [15:0] aw2,
                                logic [15:0] bw0, logic [15:0] bw1, logic [15:0] bw2);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        expected_results.push_back(float_result(op, aw0, aw1, aw2, bw0, bw1, bw2));
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {bw2, bw1, bw0, aw2, aw1, aw0};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [15:0] rand_exp_word(bit near);
        if (near) return {1'($urandom_range(0, 1)), 15'($urandom_range(16384 - 40, 16384 + 40))};
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_high_word(bit normalized);
        logic [15:0] w;
        w = 16'($urandom);
        if (normalized) w[15] = 1'b1;
        return w;
    endfunction

    // Extremes of every field and each named special case.
    task automatic test_directed();
        send_request(OP_ADD, 16'h4000, 16'h8000, 16'h0000, 16'h4000, 16'h8000, 16'h0000);
        send_request(OP_ADD, 16'h4001, 16'hFFFF, 16'hFFFF, 16'h4001, 16'hFFFF, 16'hFFFF);
        send_request(OP_ADD, 16'h4030, 16'h8000, 16'h0001, 16'h4000, 16'hC000, 16'h0000);
        send_request(OP_ADD, 16'h4000, 16'h8000, 16'h0000, 16'h4020, 16'hC000, 16'h0000);
        send_request(OP_SUB, 16'h4000, 16'h8000, 16'h0000, 16'h4000, 16'h8000, 16'h0000);
        send_request(OP_SUB, 16'h4000, 16'h8000, 16'h0000, 16'h4000, 16'h8000, 16'h0001);
        send_request(OP_SUB, 16'h4005, 16'h8000, 16'h0000, 16'h4000, 16'hFFFF, 16'hFFFF);
        send_request(OP_ADD, 16'hC000, 16'h9000, 16'h0000, 16'h4000, 16'h8000, 16'h0000);
        send_request(OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(OP_ADD, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_SUB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000);
        send_request(OP_ADD, 16'h4000, 16'h0000, 16'h0001, 16'h4000, 16'h0000, 16'h0001);
        send_request(OP_MUL, 16'h4000, 16'h8000, 16'h0000, 16'h4000, 16'h8000, 16'h0000);
        send_request(OP_MUL, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_MUL, 16'h0001, 16'h8000, 16'h0000, 16'h0001, 16'h8000, 16'h0000);
        send_request(OP_MUL, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'h0000);
        send_request(OP_DIV, 16'h4000, 16'h8000, 16'h0000, 16'h4000, 16'hC000, 16'h0000);
        send_request(OP_DIV, 16'hC123, 16'h8000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_request(OP_DIV, 16'h4000, 16'hFFFF, 16'hFFFF, 16'h4000, 16'h0000, 16'h0001);
        send_request(OP_DIV, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'h0000);
        send_request(OP_DIV, 16'h0001, 16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_DIV, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h0000);
        send_request(OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Mostly normalized operands with nearby exponents; some raw random words.
    task automatic test_random(int count);
        bit near, norm;
        for (int i = 0; i < count; i++) begin
            near = ($urandom_range(0, 9) != 0);
            norm = ($urandom_range(0, 9) != 0);
            send_request(t_op'($urandom_range(0, 3)),
                         rand_exp_word(near), rand_high_word(norm), 16'($urandom),
                         rand_exp_word(near), rand_high_word(norm), 16'($urandom));
        end
    endtask

    // Opposite-sign pairs with close mantissas drive long renormalization.
    task automatic test_cancellation(int count);
        logic [15:0] e0, m1, m2;
        for (int i = 0; i < count; i++) begin
            e0 = rand_exp_word(1'b1);
            m1 = rand_high_word(1'b1);
            m2 = 16'($urandom);
            send_request(OP_SUB, e0, m1, m2, e0 ^ 16'($urandom_range(0, 1)),
                         m1 ^ 16'($urandom_range(0, 3)), m2 ^ (16'd1 << $urandom_range(0, 15)));
        end
    endtask

    // Result checker: each returned result against the oldest prediction.
    always @(posedge i_clk) begin
        t_fres want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[15:0] !== want.w0) begin
                    $error("res_word0 expected %h actual %h", want.w0, m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (m_axis_tdata[31:16] !== want.w1) begin
                    $error("res_word1 expected %h actual %h", want.w1, m_axis_tdata[31:16]);
                    fail_count++;
                end
                if (m_axis_tdata[47:32] !== want.w2) begin
                    $error("res_word2 expected %h actual %h", want.w2, m_axis_tdata[47:32]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.dbz) begin
                    $error("divide_by_zero expected %b actual %b", want.dbz, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stalls: alternating stretches of steady ready and random stalls.
    always @(posedge i_clk) begin
        int phase;
        phase = ($time / 8) % 600;
        if (!i_rst_n || phase < 150) m_axis_tready <= 1'b1;
        else if (phase < 300) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= ($urandom_range(0, 2) == 0);
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        fail_count    = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        m_axis_tready = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_cancellation(250);
        test_random(1380);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
